>>> hdl/waypoint_go_to_goal_controller_defines.svh
// Assertion macros for the RTL.
`ifndef WAYPOINT_GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define WAYPOINT_GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define WGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WGC_ASSERT_IMP(lbl, ante, cons, msg)
`define WGC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/wgc_pkg.sv
`default_nettype none
package wgc_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int CORDIC_STEPS_DEF  = 16;

  localparam int CW     = 37;
  localparam int ZW     = 28;
  localparam int STEP_W = 5;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic [21:0] INV_GAIN_Q16 = 22'd39797;
  localparam logic [21:0] PIX_RECIP    = 22'd2236963;
  localparam int          PIX_SHIFT    = 26;
  localparam logic signed [18:0] PI_Q13     = 19'sd25736;
  localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
  localparam logic signed [16:0] MAP_Y_OFFSET = 17'sd20480;

  localparam logic [15:0] ANG_GAIN_RST  = 16'd6554;
  localparam logic [15:0] LIN_GAIN_RST  = 16'd11469;
  localparam logic [14:0] ARRIVE_RST    = 15'd205;
  localparam logic [14:0] HEAD_TOL_RST  = 15'd819;
  localparam logic [6:0]  WP_COUNT_RST  = 7'd0;

  localparam logic [2:0] REG_ANG_GAIN = 3'd0;
  localparam logic [2:0] REG_LIN_GAIN = 3'd1;
  localparam logic [2:0] REG_ARRIVE   = 3'd2;
  localparam logic [2:0] REG_HEAD_TOL = 3'd3;
  localparam logic [2:0] REG_WP_COUNT = 3'd4;

  localparam logic [2:0] MUL_NONE    = 3'd0;
  localparam logic [2:0] MUL_MAP_Y   = 3'd1;
  localparam logic [2:0] MUL_MAP_X   = 3'd2;
  localparam logic [2:0] MUL_DIST_LO = 3'd3;
  localparam logic [2:0] MUL_DIST_HI = 3'd4;
  localparam logic [2:0] MUL_TURN    = 3'd5;
  localparam logic [2:0] MUL_FWD     = 3'd6;

  typedef struct packed {
    logic              capture;
    logic              load_wr;
    logic [2:0]        mul_sel;
    logic              set_tx;
    logic              set_ty;
    logic              init_cordic;
    logic              iter;
    logic [STEP_W-1:0] step;
    logic              set_err;
    logic              set_p1;
    logic              set_dist;
    logic              arrive;
    logic              set_turn;
    logic              set_fwd;
    logic              zero_res;
    logic              out_load;
  } wgc_cmd_t;

  typedef struct packed {
    logic route_end;
    logic need_target;
    logic arrived;
    logic big_err;
  } wgc_sts_t;

  function automatic logic [23:0] atan_q24(input logic [STEP_W-1:0] i);
    logic [23:0] v;
    case (i)
      5'd0:  v = 24'd13176795;
      5'd1:  v = 24'd7778716;
      5'd2:  v = 24'd4110060;
      5'd3:  v = 24'd2086331;
      5'd4:  v = 24'd1047514;
      5'd5:  v = 24'd524117;
      5'd6:  v = 24'd262123;
      5'd7:  v = 24'd131069;
      5'd8:  v = 24'd65536;
      5'd9:  v = 24'd32768;
      5'd10: v = 24'd16384;
      5'd11: v = 24'd8192;
      5'd12: v = 24'd4096;
      5'd13: v = 24'd2048;
      5'd14: v = 24'd1024;
      5'd15: v = 24'd512;
      5'd16: v = 24'd256;
      5'd17: v = 24'd128;
      5'd18: v = 24'd64;
      5'd19: v = 24'd32;
      5'd20: v = 24'd16;
      5'd21: v = 24'd8;
      5'd22: v = 24'd4;
      5'd23: v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> hdl/wgc_ifs.sv
`default_nettype none
interface wgc_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [5:0]         load_index;
  logic [15:0]        raw_waypoint_x;
  logic [15:0]        raw_waypoint_y;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;
  modport source (output valid, func, load_index, raw_waypoint_x, raw_waypoint_y,
                  pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, func, load_index, raw_waypoint_x, raw_waypoint_y,
                pose_x, pose_y, pose_heading, output ready);
endinterface

interface wgc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] turn_rate;
  logic [14:0]        forward_speed;
  logic [6:0]         current_waypoint;
  logic               route_done;
  modport source (output valid, turn_rate, forward_speed, current_waypoint, route_done,
                  input ready);
  modport sink (input valid, turn_rate, forward_speed, current_waypoint, route_done,
                output ready);
endinterface
`default_nettype wire

>>> hdl/wgc_datapath.sv
`default_nettype none
module wgc_datapath #(
  parameter int MAX_WAYPOINTS = wgc_pkg::MAX_WAYPOINTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wgc_pkg::wgc_cmd_t  cmd,
  output wgc_pkg::wgc_sts_t       sts,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [5:0]         load_index,
  input  wire logic [15:0]        raw_waypoint_x,
  input  wire logic [15:0]        raw_waypoint_y,
  input  wire logic signed [15:0] pose_x,
  input  wire logic signed [15:0] pose_y,
  input  wire logic signed [15:0] pose_heading,
  output logic signed [15:0]      turn_rate,
  output logic [14:0]             forward_speed,
  output logic [6:0]              current_waypoint,
  output logic                    route_done
);
  localparam int AW   = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int CNTW = $clog2(MAX_WAYPOINTS + 1);
  localparam int EW   = (CNTW > 7) ? CNTW : 7;
  localparam int CW   = wgc_pkg::CW;
  localparam int ZW   = wgc_pkg::ZW;

  // configuration
  logic [15:0] ang_gain_r, lin_gain_r;
  logic [14:0] arrive_r, head_tol_r;
  logic [6:0]  wp_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_gain_r <= wgc_pkg::ANG_GAIN_RST;
      lin_gain_r <= wgc_pkg::LIN_GAIN_RST;
      arrive_r   <= wgc_pkg::ARRIVE_RST;
      head_tol_r <= wgc_pkg::HEAD_TOL_RST;
      wp_count_r <= wgc_pkg::WP_COUNT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wgc_pkg::REG_ANG_GAIN: ang_gain_r <= cfg_data;
        wgc_pkg::REG_LIN_GAIN: lin_gain_r <= cfg_data;
        wgc_pkg::REG_ARRIVE:   arrive_r   <= cfg_data[14:0];
        wgc_pkg::REG_HEAD_TOL: head_tol_r <= cfg_data[14:0];
        wgc_pkg::REG_WP_COUNT: wp_count_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // route state
  logic [6:0]  idx_r;
  logic        need_r;
  logic [EW-1:0] eff_cnt;

  always_comb begin
    if (EW'(wp_count_r) > EW'(MAX_WAYPOINTS)) eff_cnt = EW'(MAX_WAYPOINTS);
    else eff_cnt = EW'(wp_count_r);
  end

  // waypoint table
  logic [31:0] mem [MAX_WAYPOINTS];
  logic [31:0] rd_r;
  logic        slot_ok;

  assign slot_ok = (int'(load_index) < MAX_WAYPOINTS);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) mem[AW'(load_index)] <= {raw_waypoint_x, raw_waypoint_y};
    rd_r <= mem[AW'(idx_r)];
  end

  // pose latch
  logic signed [15:0] px_r, py_r, hd_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r <= pose_x;
      py_r <= pose_y;
      hd_r <= pose_heading;
    end
  end

  // shared multiplier
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [CW-1:0] xpos;
  logic [16:0]   mag_r, dist_r;
  logic          err_neg_r;
  logic [21:0]   mul_a, mul_b;
  logic [43:0]   prod_r;

  assign xpos = x_r[CW-1] ? '0 : x_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      wgc_pkg::MUL_MAP_Y: begin
        mul_a = {2'b00, rd_r[15:0], 4'hF};
        mul_b = wgc_pkg::PIX_RECIP;
      end
      wgc_pkg::MUL_MAP_X: begin
        mul_a = {2'b00, rd_r[31:16], 4'hF};
        mul_b = wgc_pkg::PIX_RECIP;
      end
      wgc_pkg::MUL_DIST_LO: begin
        mul_a = {6'd0, xpos[15:0]};
        mul_b = wgc_pkg::INV_GAIN_Q16;
      end
      wgc_pkg::MUL_DIST_HI: begin
        mul_a = 22'(xpos[CW-1:16]);
        mul_b = wgc_pkg::INV_GAIN_Q16;
      end
      wgc_pkg::MUL_TURN: begin
        mul_a = {5'd0, mag_r};
        mul_b = {6'd0, ang_gain_r};
      end
      wgc_pkg::MUL_FWD: begin
        mul_a = {5'd0, dist_r};
        mul_b = {6'd0, lin_gain_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // target mapping
  logic [15:0]        map_q;
  logic signed [15:0] tx_r, ty_r;
  logic signed [16:0] ty_full;

  assign map_q   = prod_r[wgc_pkg::PIX_SHIFT+15:wgc_pkg::PIX_SHIFT];
  assign ty_full = wgc_pkg::MAP_Y_OFFSET - $signed({1'b0, map_q});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r   <= '0;
      ty_r   <= '0;
      idx_r  <= '0;
      need_r <= 1'b1;
    end else begin
      if (cmd.set_tx) tx_r <= map_q[15] ? 16'sd32767 : $signed(map_q);
      if (cmd.set_ty) begin
        ty_r   <= ty_full[15:0];
        need_r <= 1'b0;
      end
      if (cmd.arrive) begin
        idx_r  <= idx_r + 7'd1;
        need_r <= 1'b1;
      end
    end
  end

  // vectoring CORDIC
  logic signed [16:0]   dx, dy;
  logic signed [CW-1:0] x0, y0, xs, ys;
  logic signed [ZW-1:0] atan_v;

  assign dx = 17'(tx_r) - 17'(px_r);
  assign dy = 17'(ty_r) - 17'(py_r);
  assign x0 = {{(CW-33){dx[16]}}, dx, 16'd0};
  assign y0 = {{(CW-33){dy[16]}}, dy, 16'd0};
  assign xs = x_r >>> cmd.step;
  assign ys = y_r >>> cmd.step;
  assign atan_v = $signed({4'd0, wgc_pkg::atan_q24(cmd.step)});

  always_ff @(posedge clk) begin
    if (cmd.init_cordic) begin
      if (x0[CW-1]) begin
        if (!y0[CW-1]) begin
          x_r <= y0;
          y_r <= -x0;
          z_r <= wgc_pkg::HALF_PI_Q24;
        end else begin
          x_r <= -y0;
          y_r <= x0;
          z_r <= -wgc_pkg::HALF_PI_Q24;
        end
      end else begin
        x_r <= x0;
        y_r <= y0;
        z_r <= '0;
      end
    end else if (cmd.iter) begin
      if (!y_r[CW-1] && (y_r != '0)) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end
    end
  end

  // heading error, distance
  logic signed [ZW-1:0] z_rnd;
  logic signed [18:0]   err_raw, err_w;
  logic [31:0]          p1_r;
  logic [53:0]          dist_sum;

  assign z_rnd   = z_r + 28'sd1024;
  assign err_raw = 19'(z_rnd >>> 11) - 19'(hd_r);

  always_comb begin
    if (err_raw > wgc_pkg::PI_Q13) err_w = err_raw - wgc_pkg::TWO_PI_Q13;
    else if (err_raw < -wgc_pkg::PI_Q13) err_w = err_raw + wgc_pkg::TWO_PI_Q13;
    else err_w = err_raw;
  end

  assign dist_sum = {1'b0, prod_r[36:0], 16'd0} + {22'd0, p1_r} + {22'd0, 1'b1, 31'd0};

  always_ff @(posedge clk) begin
    if (cmd.set_err) begin
      err_neg_r <= err_w[18];
      mag_r     <= err_w[18] ? 17'(-err_w) : 17'(err_w);
    end
    if (cmd.set_p1) p1_r <= prod_r[31:0];
    if (cmd.set_dist) dist_r <= dist_sum[48:32];
  end

  // commands
  logic [19:0]        prod_rnd;
  logic signed [15:0] res_turn_r;
  logic [14:0]        res_fwd_r;

  assign prod_rnd = 20'((prod_r[33:0] + 34'd8192) >> 14);

  always_ff @(posedge clk) begin
    if (cmd.zero_res) begin
      res_turn_r <= '0;
      res_fwd_r  <= '0;
    end else if (cmd.set_turn) begin
      res_fwd_r <= '0;
      if (err_neg_r) res_turn_r <= (prod_rnd > 20'd32768) ? -16'sd32768 : 16'(-prod_rnd);
      else res_turn_r <= (prod_rnd > 20'd32767) ? 16'sd32767 : 16'(prod_rnd);
    end else if (cmd.set_fwd) begin
      res_turn_r <= '0;
      res_fwd_r  <= (prod_rnd > 20'd32767) ? 15'h7FFF : prod_rnd[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      turn_rate        <= res_turn_r;
      forward_speed    <= res_fwd_r;
      current_waypoint <= idx_r;
      route_done       <= (EW'(idx_r) >= eff_cnt);
    end
  end

  assign sts.route_end   = (EW'(idx_r) >= eff_cnt);
  assign sts.need_target = need_r;
  assign sts.arrived     = (dist_r <= {2'b00, arrive_r});
  assign sts.big_err     = (mag_r > {2'b00, head_tol_r});

endmodule
`default_nettype wire

>>> hdl/wgc_ctrl.sv
`default_nettype none
`include "waypoint_go_to_goal_controller_defines.svh"
module wgc_ctrl #(
  parameter int CORDIC_STEPS = wgc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire wgc_pkg::wgc_sts_t sts,
  output wgc_pkg::wgc_cmd_t      cmd
);
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHK   = 4'd1;
  localparam logic [3:0] ST_MAP1  = 4'd2;
  localparam logic [3:0] ST_MAP2  = 4'd3;
  localparam logic [3:0] ST_MAP3  = 4'd4;
  localparam logic [3:0] ST_PRE   = 4'd5;
  localparam logic [3:0] ST_ITER  = 4'd6;
  localparam logic [3:0] ST_DIST1 = 4'd7;
  localparam logic [3:0] ST_DIST2 = 4'd8;
  localparam logic [3:0] ST_DIST3 = 4'd9;
  localparam logic [3:0] ST_DEC   = 4'd10;
  localparam logic [3:0] ST_TURN  = 4'd11;
  localparam logic [3:0] ST_FWD   = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  localparam logic [wgc_pkg::STEP_W-1:0] LAST_STEP = wgc_pkg::STEP_W'(CORDIC_STEPS - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [wgc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.capture   = accept && in_func;
    cmd.load_wr   = accept && !in_func;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (accept && in_func) state_nxt = ST_CHK;
      ST_CHK: begin
        if (sts.route_end) begin
          cmd.zero_res = 1'b1;
          state_nxt    = ST_OUT;
        end else if (sts.need_target) begin
          state_nxt = ST_MAP1;
        end else begin
          state_nxt = ST_PRE;
        end
      end
      ST_MAP1: begin
        cmd.mul_sel = wgc_pkg::MUL_MAP_Y;
        state_nxt   = ST_MAP2;
      end
      ST_MAP2: begin
        cmd.set_tx  = 1'b1;
        cmd.mul_sel = wgc_pkg::MUL_MAP_X;
        state_nxt   = ST_MAP3;
      end
      ST_MAP3: begin
        cmd.set_ty = 1'b1;
        state_nxt  = ST_PRE;
      end
      ST_PRE: begin
        cmd.init_cordic = 1'b1;
        step_nxt        = '0;
        state_nxt       = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) state_nxt = ST_DIST1;
      end
      ST_DIST1: begin
        cmd.set_err = 1'b1;
        cmd.mul_sel = wgc_pkg::MUL_DIST_LO;
        state_nxt   = ST_DIST2;
      end
      ST_DIST2: begin
        cmd.set_p1  = 1'b1;
        cmd.mul_sel = wgc_pkg::MUL_DIST_HI;
        state_nxt   = ST_DIST3;
      end
      ST_DIST3: begin
        cmd.set_dist = 1'b1;
        state_nxt    = ST_DEC;
      end
      ST_DEC: begin
        if (sts.arrived) begin
          cmd.arrive   = 1'b1;
          cmd.zero_res = 1'b1;
          state_nxt    = ST_OUT;
        end else if (sts.big_err) begin
          cmd.mul_sel = wgc_pkg::MUL_TURN;
          state_nxt   = ST_TURN;
        end else begin
          cmd.mul_sel = wgc_pkg::MUL_FWD;
          state_nxt   = ST_FWD;
        end
      end
      ST_TURN: begin
        cmd.set_turn = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_FWD: begin
        cmd.set_fwd = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WGC_ASSERT_NXT(a_pose_start, accept && in_func, state_r == ST_CHK, "pose transfer lost")
  `WGC_ASSERT_NXT(a_iter_exit, state_r == ST_ITER && step_r == LAST_STEP, state_r == ST_DIST1, "cordic overrun")
  `WGC_ASSERT_IMP(a_step_range, state_r == ST_ITER, step_r <= LAST_STEP, "step out of range")
  `WGC_ASSERT_NXT(a_out_hold, state_r == ST_OUT && out_valid_r && !out_ready, state_r == ST_OUT, "result overwritten")

endmodule
`default_nettype wire

>>> hdl/waypoint_go_to_goal_controller.sv
`default_nettype none
// Waypoint go-to-goal controller.
// in_ch: func 0 loads one raw pixel waypoint into the table (no result);
// func 1 is a pose tick that returns exactly one result on out_ch.
// cfg_*: register writes (gains, arrive distance, heading tolerance,
// waypoint count): user writes only while the block is idle, not enforced.
// A pose tick first maps a new target when one is pending, then runs the
// CORDIC loop, one iteration per cycle, and the distance and command
// products on the shared multiplier; on arrival it skips the command product.
// Pose ticks with no route left go straight to output with a zero result.
// One item is in work at a time.
// Reset clears the route (target 0, target mapping pending) and loads the
// register defaults; the table is undefined until loaded.
// A stalled receiver holds the result in the output register; the block can
// take and process the next item and waits only when its own result is ready.
module waypoint_go_to_goal_controller #(
  parameter int MAX_WAYPOINTS = wgc_pkg::MAX_WAYPOINTS_DEF,
  parameter int CORDIC_STEPS  = wgc_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wgc_in_if.sink           in_ch,
  wgc_out_if.source        out_ch,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  wgc_pkg::wgc_cmd_t cmd;
  wgc_pkg::wgc_sts_t sts;

  wgc_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_func  (in_ch.func),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wgc_datapath #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .load_index      (in_ch.load_index),
    .raw_waypoint_x  (in_ch.raw_waypoint_x),
    .raw_waypoint_y  (in_ch.raw_waypoint_y),
    .pose_x          (in_ch.pose_x),
    .pose_y          (in_ch.pose_y),
    .pose_heading    (in_ch.pose_heading),
    .turn_rate       (out_ch.turn_rate),
    .forward_speed   (out_ch.forward_speed),
    .current_waypoint(out_ch.current_waypoint),
    .route_done      (out_ch.route_done)
  );

endmodule
`default_nettype wire
